/* sv/i2cm_pkg.sv */
// Package: types, phase codes and constants for the I2C master engine.
`timescale 1ns / 1ps
package i2cm_pkg;

    localparam int RECOVERY_PULSES_DEF     = 9;
    localparam int RECOVERY_HALF_TICKS_DEF = 5;
    localparam logic [9:0]  HALF_PERIOD_RST     = 10'd5;
    localparam logic [15:0] STRETCH_TIMEOUT_RST = 16'd1000;

    localparam logic [0:0] REG_HALF_PERIOD     = 1'b0;
    localparam logic [0:0] REG_STRETCH_TIMEOUT = 1'b1;

    localparam logic [2:0] OP_WRITE   = 3'd1;
    localparam logic [2:0] OP_READ    = 3'd2;
    localparam logic [2:0] OP_REG_WR  = 3'd3;
    localparam logic [2:0] OP_REG_RD  = 3'd4;
    localparam logic [2:0] OP_RECOVER = 3'd5;

    typedef enum logic [4:0] {
        PH_IDLE, PH_S_REL, PH_S_STR, PH_S_SDA, PH_S_SCL,
        PH_B_SDA, PH_B_REL, PH_B_STR, PH_B_END,
        PH_P_SDA, PH_P_REL, PH_P_STR, PH_P_SDAREL, PH_FIN,
        PH_R_REL, PH_R_LOW, PH_R_HIGH, PH_R_CHK, PH_R_P2, PH_R_P3
    } t_phase;

    typedef enum logic [2:0] {
        SEG_ADDR, SEG_REGHI, SEG_REGLO, SEG_TX, SEG_ADDR_RD, SEG_RX
    } t_seg;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  dev_addr;
        logic [15:0] reg_addr;
        logic        reg_wide;
        logic [15:0] length;
        logic [7:0]  tx_byte;
        logic        scl_level;
        logic        sda_level;
    } t_in_item;

    typedef struct packed {
        logic        scl_pull_low;
        logic        sda_pull_low;
        logic        tx_taken;
        logic        rx_valid;
        logic [7:0]  rx_byte;
        logic        done_res;
        logic        failed;
        logic        busy_res;
    } t_out_item;

endpackage

/* sv/i2cm_core.sv */
// Sequencer core: one tick of the I2C master state held in registers.
`timescale 1ns / 1ps
module i2cm_core
    import i2cm_pkg::*;
#(
    parameter int RECOVERY_PULSES     = RECOVERY_PULSES_DEF,
    parameter int RECOVERY_HALF_TICKS = RECOVERY_HALF_TICKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_in_item    i_item,
    input  logic [9:0]  i_half_period,
    input  logic [15:0] i_stretch_timeout,
    output t_out_item   o_item
);
    localparam logic [3:0] RecPulses = 4'(RECOVERY_PULSES);
    localparam logic [9:0] RecHalf   = 10'(RECOVERY_HALF_TICKS);

    t_phase      r_phase, n_phase;
    t_seg        r_seg, n_seg;
    logic [3:0]  r_bit, n_bit;
    logic [15:0] r_bytes, n_bytes;
    logic [7:0]  r_shift, n_shift;
    logic [9:0]  r_wait, n_wait;
    logic [15:0] r_str, n_str;
    logic [2:0]  r_cmd, n_cmd;
    logic [7:0]  r_addr, n_addr;
    logic [15:0] r_reg, n_reg;
    logic        r_wide, n_wide;
    logic [15:0] r_len, n_len;
    logic        r_err, n_err;
    logic [3:0]  r_pulse, n_pulse;
    logic        r_scl, n_scl, r_sda, n_sda;
    t_out_item   res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_seg <= SEG_ADDR; r_bit <= '0; r_bytes <= '0;
            r_shift <= '0; r_wait <= '0; r_str <= '0; r_cmd <= '0; r_addr <= '0;
            r_reg <= '0; r_wide <= 1'b0; r_len <= '0; r_err <= 1'b0;
            r_pulse <= '0; r_scl <= 1'b0; r_sda <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase; r_seg <= n_seg; r_bit <= n_bit; r_bytes <= n_bytes;
            r_shift <= n_shift; r_wait <= n_wait; r_str <= n_str; r_cmd <= n_cmd;
            r_addr <= n_addr; r_reg <= n_reg; r_wide <= n_wide; r_len <= n_len;
            r_err <= n_err; r_pulse <= n_pulse; r_scl <= n_scl; r_sda <= n_sda;
        end
    end

    always_comb begin
        logic        rx;
        logic [15:0] str_inc;
        logic        do_load;
        logic [7:0]  load_val;
        logic        nd;
        logic [16:0] bytes_p1;
        n_phase = r_phase; n_seg = r_seg; n_bit = r_bit; n_bytes = r_bytes;
        n_shift = r_shift; n_wait = r_wait; n_str = r_str; n_cmd = r_cmd;
        n_addr = r_addr; n_reg = r_reg; n_wide = r_wide; n_len = r_len;
        n_err = r_err; n_pulse = r_pulse; n_scl = r_scl; n_sda = r_sda;
        res = '0;
        do_load = 1'b0; load_val = '0; nd = 1'b0;

        // accept a command in idle
        if (r_phase == PH_IDLE && i_item.op >= OP_WRITE && i_item.op <= OP_RECOVER) begin
            n_cmd = i_item.op; n_addr = i_item.dev_addr; n_reg = i_item.reg_addr;
            n_wide = i_item.reg_wide; n_len = i_item.length;
            n_bytes = '0; n_err = 1'b0; n_wait = '0; n_str = '0; n_pulse = '0;
            n_bit = '0;
            n_seg = (i_item.op == OP_READ) ? SEG_ADDR_RD : SEG_ADDR;
            n_phase = (i_item.op == OP_RECOVER) ? PH_R_REL : PH_S_REL;
        end

        rx = (n_seg == SEG_RX);
        str_inc = n_str + 16'd1;
        bytes_p1 = {1'b0, n_bytes} + 17'd1;

        if (n_phase != PH_IDLE) begin
            if (n_wait != '0) begin
                n_wait = n_wait - 10'd1;
            end else begin
                unique case (n_phase)
                    PH_S_REL: begin
                        n_sda = 1'b0; n_scl = 1'b0; n_str = '0; n_phase = PH_S_STR;
                    end
                    PH_S_STR, PH_B_STR: begin
                        if (i_item.scl_level) begin
                            n_str = '0; n_wait = i_half_period;
                            n_phase = (n_phase == PH_S_STR) ? PH_S_SDA : PH_B_END;
                        end else begin
                            n_str = str_inc;
                            if (str_inc == '0 || str_inc >= i_stretch_timeout) begin
                                n_err = 1'b1; n_str = '0; n_phase = PH_P_SDA;
                            end
                        end
                    end
                    PH_S_SDA: begin
                        n_sda = 1'b1; n_wait = i_half_period; n_phase = PH_S_SCL;
                    end
                    PH_S_SCL: begin
                        n_scl = 1'b1; do_load = 1'b1;
                        load_val = (n_seg == SEG_ADDR_RD) ? (n_addr | 8'h01) : n_addr;
                    end
                    PH_B_SDA: begin
                        if (n_bit < 4'd8) n_sda = rx ? 1'b0 : ~n_shift[7];
                        else n_sda = rx ? (bytes_p1 < {1'b0, n_len}) : 1'b0;
                        n_wait = i_half_period; n_phase = PH_B_REL;
                    end
                    PH_B_REL, PH_P_REL: begin
                        n_scl = 1'b0; n_str = '0;
                        n_phase = (n_phase == PH_B_REL) ? PH_B_STR : PH_P_STR;
                    end
                    PH_B_END: begin
                        n_scl = 1'b1;
                        if (n_bit < 4'd8) begin
                            n_shift = {n_shift[6:0], rx & i_item.sda_level};
                            n_bit = n_bit + 4'd1; n_phase = PH_B_SDA;
                        end else if (rx) begin
                            res.rx_valid = 1'b1; res.rx_byte = n_shift;
                            n_bytes = bytes_p1[15:0]; nd = 1'b1;
                        end else if (i_item.sda_level) begin
                            n_err = 1'b1; n_str = '0; n_phase = PH_P_SDA;
                        end else begin
                            case (n_seg)
                                SEG_ADDR: begin
                                    if (n_cmd == OP_WRITE) begin
                                        n_seg = SEG_TX; nd = 1'b1;
                                    end else if (n_wide) begin
                                        n_seg = SEG_REGHI; do_load = 1'b1;
                                        load_val = n_reg[15:8];
                                    end else begin
                                        n_seg = SEG_REGLO; do_load = 1'b1;
                                        load_val = n_reg[7:0];
                                    end
                                end
                                SEG_REGHI: begin
                                    n_seg = SEG_REGLO; do_load = 1'b1;
                                    load_val = n_reg[7:0];
                                end
                                SEG_REGLO: begin
                                    if (n_cmd == OP_REG_RD) begin
                                        n_seg = SEG_ADDR_RD; n_phase = PH_S_REL;
                                    end else begin
                                        n_seg = SEG_TX; nd = 1'b1;
                                    end
                                end
                                SEG_TX: begin
                                    n_bytes = bytes_p1[15:0]; nd = 1'b1;
                                end
                                default: begin
                                    n_seg = SEG_RX; nd = 1'b1;
                                end
                            endcase
                        end
                    end
                    PH_P_SDA: begin
                        n_sda = 1'b1; n_wait = i_half_period; n_phase = PH_P_REL;
                    end
                    PH_P_STR: begin
                        n_str = str_inc;
                        if (i_item.scl_level || str_inc == '0 ||
                            str_inc >= i_stretch_timeout) begin
                            n_str = '0; n_wait = i_half_period; n_phase = PH_P_SDAREL;
                        end
                    end
                    PH_P_SDAREL: begin
                        n_sda = 1'b0; n_wait = i_half_period; n_phase = PH_FIN;
                    end
                    PH_FIN: begin
                        res.done_res = 1'b1; res.failed = n_err; n_phase = PH_IDLE;
                    end
                    PH_R_REL: begin
                        n_sda = 1'b0; n_phase = PH_R_LOW;
                    end
                    PH_R_LOW: begin
                        n_scl = 1'b1; n_wait = RecHalf; n_phase = PH_R_HIGH;
                    end
                    PH_R_HIGH: begin
                        n_scl = 1'b0; n_wait = RecHalf; n_phase = PH_R_CHK;
                    end
                    PH_R_CHK: begin
                        n_pulse = n_pulse + 4'd1;
                        if (i_item.sda_level || n_pulse >= RecPulses) begin
                            n_sda = 1'b1; n_phase = PH_R_P2;
                        end else begin
                            n_scl = 1'b1; n_phase = PH_R_HIGH;
                        end
                        n_wait = RecHalf;
                    end
                    PH_R_P2: begin
                        n_scl = 1'b0; n_wait = RecHalf; n_phase = PH_R_P3;
                    end
                    PH_R_P3: begin
                        n_sda = 1'b0; n_wait = RecHalf; n_phase = PH_FIN;
                    end
                    default: n_phase = PH_IDLE;
                endcase
                // next data byte or stop
                if (nd) begin
                    if (n_bytes >= n_len) begin
                        n_phase = PH_P_SDA;
                    end else if (n_seg == SEG_TX) begin
                        do_load = 1'b1; load_val = i_item.tx_byte; res.tx_taken = 1'b1;
                    end else begin
                        do_load = 1'b1; load_val = '0;
                    end
                end
                if (do_load) begin
                    n_shift = load_val; n_bit = '0; n_phase = PH_B_SDA;
                end
            end
        end
        res.scl_pull_low = n_scl;
        res.sda_pull_low = n_sda;
        res.busy_res = (n_phase != PH_IDLE);
    end

    assign o_item = res;
endmodule

/* sv/i2c_master_transaction_engine.sv */
// Top level: I2C master engine with item handshakes and config registers.
`timescale 1ns / 1ps
// Usage:
//   Each input item is one timing tick: a command code (0 = tick only),
//   command operands, the next tx byte and the sampled SCL/SDA levels.
//   Each accepted item yields exactly one result item: line drives,
//   tx_taken / rx_valid / done pulses and busy.
// Channels: valid/ready on both sides. The sequencer state and the result
//   register advance together at the accepting edge; the result appears
//   in the cycle after acceptance.
// Throughput: one item per cycle while results are taken. The single
//   result register is the only buffer: a new item is accepted whenever
//   the result register is empty or is being taken in the same cycle.
// Receiver stall: the result holds, ready drops, the sequencer holds.
// Configuration: i_cfg_we writes half_period (index 0) or stretch_timeout
//   (index 1) at once; the index is a single bit.
// Reset: synchronous, active low; bus released, phase idle, config to
//   defaults (5 and 1000), no result pending.
module i2c_master_transaction_engine
    import i2cm_pkg::*;
#(
    parameter int RECOVERY_PULSES     = RECOVERY_PULSES_DEF,
    parameter int RECOVERY_HALF_TICKS = RECOVERY_HALF_TICKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);
    logic        r_valid;
    t_out_item   r_data;
    logic [9:0]  r_half;
    logic [15:0] r_tout;
    logic        step;
    t_out_item   core_res;

    // accept when the result slot is free or drains this cycle
    assign o_ready = !r_valid || i_ready;
    assign step    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_PERIOD_RST;
            r_tout <= STRETCH_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HALF_PERIOD:     r_half <= i_cfg_wdata[9:0];
                REG_STRETCH_TIMEOUT: r_tout <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    i2cm_core #(
        .RECOVERY_PULSES    (RECOVERY_PULSES),
        .RECOVERY_HALF_TICKS(RECOVERY_HALF_TICKS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_item           (i_data),
        .i_half_period    (r_half),
        .i_stretch_timeout(r_tout),
        .o_item           (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (step) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // hold payload until taken
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_data <= core_res;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

/* test/tb.sv */
// Testbench for the I2C master transaction engine: directed table, then random ticks.
`timescale 1ns / 1ps
module tb;
    import i2cm_pkg::*;

    // Predictor sequencer codes (own copy, mirrors the package ordering)
    typedef enum logic [4:0] {
        S_IDLE, S_ST_REL, S_ST_STR, S_ST_SDA, S_ST_SCL,
        S_BT_SDA, S_BT_REL, S_BT_STR, S_BT_END,
        S_SP_SDA, S_SP_REL, S_SP_STR, S_SP_SDAREL, S_DONE,
        S_RC_REL, S_RC_LOW, S_RC_HIGH, S_RC_CHK, S_RC_P2, S_RC_P3
    } t_step;

    typedef enum logic [2:0] {
        B_ADDR, B_REGHI, B_REGLO, B_TX, B_ADDR_RD, B_RX
    } t_byte_kind;

    localparam logic [2:0] OP_TICK = 3'd0;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam logic [3:0] RCV_PULSES = 4'(RECOVERY_PULSES_DEF);
    localparam logic [9:0] RCV_HALF = 10'(RECOVERY_HALF_TICKS_DEF);

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    i2c_master_transaction_engine u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_data(in_data),
        .o_valid(out_valid), .i_ready(out_ready), .o_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_wdata(cfg_wdata)
    );

    always begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    // Predictor state
    logic [9:0]  m_half;
    logic [15:0] m_tmo;
    t_step       m_step;
    logic [3:0]  m_bit;
    logic [15:0] m_bytes;
    logic [7:0]  m_shift;
    logic [9:0]  m_wait;
    logic [15:0] m_str;
    logic [2:0]  m_cmd;
    logic [7:0]  m_addr;
    logic [15:0] m_reg;
    logic        m_wide;
    logic [15:0] m_len;
    logic        m_err;
    logic [3:0]  m_pulse;
    logic        m_scl_pull;
    logic        m_sda_pull;
    t_byte_kind  m_kind;
    t_out_item   m_res;

    t_out_item expected_q[$];
    int  mismatches;
    int  sent_count;
    int  idle_in_pct;
    int  stall_out_pct;
    bit  hold_off;
    int  cycle;

    task automatic model_reset();
        m_half = HALF_PERIOD_RST; m_tmo = STRETCH_TIMEOUT_RST;
        m_step = S_IDLE; m_bit = '0; m_bytes = '0; m_shift = '0; m_wait = '0;
        m_str = '0; m_cmd = '0; m_addr = '0; m_reg = '0; m_wide = 1'b0; m_len = '0;
        m_err = 1'b0; m_pulse = '0; m_scl_pull = 1'b0; m_sda_pull = 1'b0;
        m_kind = B_ADDR;
    endtask

    task automatic go_load(input logic [7:0] b);
        m_shift = b; m_bit = '0; m_step = S_BT_SDA;
    endtask

    task automatic go_fail();
        m_err = 1'b1; m_str = '0; m_step = S_SP_SDA;
    endtask

    task automatic wait_scl(input logic scl, input t_step nxt);
        if (scl) begin
            m_str = '0; m_wait = m_half; m_step = nxt;
        end else begin
            m_str = m_str + 16'd1;
            if (m_str == 16'd0 || m_str >= m_tmo) go_fail();
        end
    endtask

    task automatic next_data(input logic [7:0] tx);
        if (m_bytes >= m_len) m_step = S_SP_SDA;
        else if (m_kind == B_TX) begin
            go_load(tx); m_res.tx_taken = 1'b1;
        end else go_load(8'h00);
    endtask

    task automatic byte_sent(input logic [7:0] tx);
        case (m_kind)
            B_ADDR: begin
                if (m_cmd == OP_WRITE) begin
                    m_kind = B_TX; next_data(tx);
                end else if (m_wide) begin
                    m_kind = B_REGHI; go_load(m_reg[15:8]);
                end else begin
                    m_kind = B_REGLO; go_load(m_reg[7:0]);
                end
            end
            B_REGHI: begin
                m_kind = B_REGLO; go_load(m_reg[7:0]);
            end
            B_REGLO: begin
                if (m_cmd == OP_REG_RD) begin
                    m_kind = B_ADDR_RD; m_step = S_ST_REL;
                end else begin
                    m_kind = B_TX; next_data(tx);
                end
            end
            B_TX: begin
                m_bytes = m_bytes + 16'd1; next_data(tx);
            end
            default: begin
                m_kind = B_RX; next_data(tx);
            end
        endcase
    endtask

    task automatic run_step(input logic scl, input logic sda, input logic [7:0] tx);
        logic rx;
        rx = (m_kind == B_RX);
        case (m_step)
            S_ST_REL: begin
                m_sda_pull = 1'b0; m_scl_pull = 1'b0; m_str = '0; m_step = S_ST_STR;
            end
            S_ST_STR: wait_scl(scl, S_ST_SDA);
            S_ST_SDA: begin
                m_sda_pull = 1'b1; m_wait = m_half; m_step = S_ST_SCL;
            end
            S_ST_SCL: begin
                m_scl_pull = 1'b1;
                go_load(m_kind == B_ADDR_RD ? (m_addr | 8'h01) : m_addr);
            end
            S_BT_SDA: begin
                if (m_bit < 4'd8) m_sda_pull = rx ? 1'b0 : ~m_shift[7];
                else m_sda_pull = rx ? ({16'd0, m_bytes} + 32'd1 < {16'd0, m_len}) : 1'b0;
                m_wait = m_half; m_step = S_BT_REL;
            end
            S_BT_REL: begin
                m_scl_pull = 1'b0; m_str = '0; m_step = S_BT_STR;
            end
            S_BT_STR: wait_scl(scl, S_BT_END);
            S_BT_END: begin
                m_scl_pull = 1'b1;
                if (m_bit < 4'd8) begin
                    m_shift = {m_shift[6:0], rx ? sda : 1'b0};
                    m_bit = m_bit + 4'd1; m_step = S_BT_SDA;
                end else if (rx) begin
                    m_res.rx_valid = 1'b1; m_res.rx_byte = m_shift;
                    m_bytes = m_bytes + 16'd1; next_data(tx);
                end else if (sda) go_fail();
                else byte_sent(tx);
            end
            S_SP_SDA: begin
                m_sda_pull = 1'b1; m_wait = m_half; m_step = S_SP_REL;
            end
            S_SP_REL: begin
                m_scl_pull = 1'b0; m_str = '0; m_step = S_SP_STR;
            end
            S_SP_STR: begin
                m_str = m_str + 16'd1;
                if (scl || m_str == 16'd0 || m_str >= m_tmo) begin
                    m_str = '0; m_wait = m_half; m_step = S_SP_SDAREL;
                end
            end
            S_SP_SDAREL: begin
                m_sda_pull = 1'b0; m_wait = m_half; m_step = S_DONE;
            end
            S_DONE: begin
                m_res.done_res = 1'b1; m_res.failed = m_err; m_step = S_IDLE;
            end
            S_RC_REL: begin
                m_sda_pull = 1'b0; m_step = S_RC_LOW;
            end
            S_RC_LOW: begin
                m_scl_pull = 1'b1; m_wait = RCV_HALF; m_step = S_RC_HIGH;
            end
            S_RC_HIGH: begin
                m_scl_pull = 1'b0; m_wait = RCV_HALF; m_step = S_RC_CHK;
            end
            S_RC_CHK: begin
                m_pulse = m_pulse + 4'd1;
                if (sda || m_pulse >= RCV_PULSES) begin
                    m_sda_pull = 1'b1; m_step = S_RC_P2;
                end else begin
                    m_scl_pull = 1'b1; m_step = S_RC_HIGH;
                end
                m_wait = RCV_HALF;
            end
            S_RC_P2: begin
                m_scl_pull = 1'b0; m_wait = RCV_HALF; m_step = S_RC_P3;
            end
            S_RC_P3: begin
                m_sda_pull = 1'b0; m_wait = RCV_HALF; m_step = S_DONE;
            end
            default: m_step = S_IDLE;
        endcase
    endtask

    // Advance the predictor by one tick and return the expected result item.
    task automatic predict_tick(input t_in_item it, output t_out_item res);
        m_res = '0;
        if (m_step == S_IDLE && it.op >= OP_WRITE && it.op <= OP_RECOVER) begin
            m_cmd = it.op; m_addr = it.dev_addr; m_reg = it.reg_addr;
            m_wide = it.reg_wide; m_len = it.length;
            m_bytes = '0; m_err = 1'b0; m_wait = '0; m_str = '0; m_pulse = '0; m_bit = '0;
            m_kind = (it.op == OP_READ) ? B_ADDR_RD : B_ADDR;
            m_step = (it.op == OP_RECOVER) ? S_RC_REL : S_ST_REL;
        end
        if (m_step != S_IDLE) begin
            if (m_wait != '0) m_wait = m_wait - 10'd1;
            else run_step(it.scl_level, it.sda_level, it.tx_byte);
        end
        m_res.scl_pull_low = m_scl_pull;
        m_res.sda_pull_low = m_sda_pull;
        m_res.busy_res = (m_step != S_IDLE);
        res = m_res;
    endtask

    // Offer one item; hold it until the block takes it, then queue its expectation.
    task automatic send_tick(input t_in_item it, input bit use_typed, input t_out_item typed);
        t_out_item exp_res;
        while ($urandom_range(99) < idle_in_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_tick(it, exp_res);
        if (use_typed) exp_res = typed;
        expected_q.push_back(exp_res);
        sent_count++;
    endtask

    // Check each result item against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %p", out_data);
            end else begin
                t_out_item e;
                e = expected_q.pop_front();
                if (e !== out_data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at cycle %0d: expected %p got %p", cycle, e, out_data);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge clk) begin
        if (!rst_n) out_ready <= 1'b0;
        else if (hold_off) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(99) >= stall_out_pct);
    end

    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_HALF_PERIOD) m_half = val[9:0];
        else m_tmo = val;
    endtask

    // Pick pin levels: mostly a cooperative slave (SCL high, ACKs), some noise.
    function automatic t_in_item rand_tick(input int noise_pct);
        t_in_item it;
        it = '0;
        it.tx_byte = 8'($urandom_range(255));
        it.scl_level = ($urandom_range(99) >= noise_pct / 2);
        it.sda_level = ($urandom_range(99) < noise_pct) ? 1'b1 : 1'($urandom_range(1));
        if (m_step == S_BT_END && m_kind != B_RX && m_bit == 4'd8)
            it.sda_level = ($urandom_range(99) < noise_pct / 3);
        if (m_step == S_IDLE && $urandom_range(3) != 0) begin
            it.op = 3'($urandom_range(7));
            it.dev_addr = 8'($urandom_range(255));
            it.reg_addr = 16'($urandom_range(65535));
            it.reg_wide = 1'($urandom_range(1));
            it.length = ($urandom_range(19) == 0) ? 16'($urandom_range(65535))
                                                  : 16'($urandom_range(3));
        end else if ($urandom_range(9) == 0) begin
            it.op = 3'($urandom_range(7));
            it.dev_addr = 8'($urandom_range(255));
            it.reg_addr = 16'($urandom_range(65535));
            it.length = 16'($urandom_range(65535));
        end
        return it;
    endfunction

    typedef struct {
        t_in_item  it;
        bit        typed_ok;
        t_out_item res;
    } t_row;

    t_row dir_rows[$];

    initial begin
        t_in_item  it;
        t_out_item none;
        t_row      r;
        int        phase_no;
        int        n;
        int        k;
        rst_n = 1'b0; in_valid = 1'b0; in_data = '0; cfg_we = 1'b0;
        cfg_index = REG_HALF_PERIOD; cfg_wdata = '0; hold_off = 1'b0;
        mismatches = 0; sent_count = 0; cycle = 0;
        idle_in_pct = 0; stall_out_pct = 0; none = '0;
        model_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: results typed in only for idle ticks right after reset.
        r.typed_ok = 1'b1; r.res = '0;
        r.it = '0; r.it.op = OP_TICK; r.it.scl_level = 1'b1; r.it.sda_level = 1'b1;
        dir_rows.push_back(r);
        r.it = '1; r.it.op = 3'd6; dir_rows.push_back(r);
        r.it.op = 3'd7; dir_rows.push_back(r);
        r.it = '0; dir_rows.push_back(r);
        foreach (dir_rows[i]) send_tick(dir_rows[i].it, dir_rows[i].typed_ok, dir_rows[i].res);

        // Each command with extreme operands, small half period; SCL never stretched.
        drain();
        write_reg(REG_HALF_PERIOD, 16'd1);
        for (k = 1; k <= 5; k++) begin
            it = '0;
            it.op = k[2:0]; it.dev_addr = (k % 2) ? 8'hFF : 8'h00;
            it.reg_addr = (k % 2) ? 16'hFFFF : 16'h0000; it.reg_wide = k[0];
            it.length = (k == 3) ? 16'd0 : 16'd2;
            it.tx_byte = 8'hA5; it.scl_level = 1'b1; it.sda_level = 1'b0;
            send_tick(it, 1'b0, none);
            while (m_step != S_IDLE) begin
                it = '0; it.tx_byte = 8'h5A; it.scl_level = 1'b1; it.sda_level = k[1];
                send_tick(it, 1'b0, none);
            end
        end
        // A stretch timeout with SDA high, and an op offered while busy.
        drain();
        write_reg(REG_STRETCH_TIMEOUT, 16'd1);
        it = '0; it.op = OP_WRITE; it.length = 16'hFFFF; it.scl_level = 1'b0;
        it.sda_level = 1'b1;
        for (k = 0; k < 12; k++) begin
            send_tick(it, 1'b0, none);
            it.op = OP_READ;
        end
        drain();

        // Random phases over several register settings.
        for (phase_no = 0; phase_no < 8; phase_no++) begin
            case (phase_no % 4)
                0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
                1: begin idle_in_pct = 60; stall_out_pct = 0;  end
                2: begin idle_in_pct = 0;  stall_out_pct = 60; end
                default: begin idle_in_pct = 33; stall_out_pct = 33; end
            endcase
            drain();
            case (phase_no)
                0: begin write_reg(REG_HALF_PERIOD, 16'd0); write_reg(REG_STRETCH_TIMEOUT, 16'd0); end
                1: begin write_reg(REG_HALF_PERIOD, 16'd1); write_reg(REG_STRETCH_TIMEOUT, 16'd3); end
                2: begin write_reg(REG_HALF_PERIOD, 16'd2); write_reg(REG_STRETCH_TIMEOUT, 16'hFFFF); end
                3: begin write_reg(REG_HALF_PERIOD, 16'd1023); write_reg(REG_STRETCH_TIMEOUT, 16'd1000); end
                default: begin
                    write_reg(REG_HALF_PERIOD, 16'($urandom_range(3)));
                    write_reg(REG_STRETCH_TIMEOUT, 16'($urandom_range(1, 8)));
                end
            endcase
            n = (phase_no == 3) ? 40 : 60;
            for (k = 0; k < n; k++) send_tick(rand_tick(phase_no * 5), 1'b0, none);
            if (phase_no == 2) begin
                // Hold the receiver off while the sender keeps offering items.
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (50) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    for (k = 0; k < 20; k++) send_tick(rand_tick(0), 1'b0, none);
                join
            end
        end

        drain();
        repeat (5) @(posedge clk);
        if (mismatches == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
